// ----- rtl/core/cdon_pkg.sv -----
// Shared types and constants for the calendar date offset and normalize block.
// Used by cdon_len_unit, cdon_core and calendar_date_offset_normalize.
// No dependencies.
package cdon_pkg;

    // Internal widths, sized to the worst-case intermediate values.
    localparam int YEAR_W = 18;   // year during normalization
    localparam int MON_W  = 14;   // month before wrapping into 1..12
    localparam int DAY_W  = 17;   // running day count
    localparam int RES_W  = 9;    // year modulo 400
    localparam int ACC_W  = 17;   // biased year for the residue reduction
    localparam int CNT_W  = 3;    // residue reduction step counter

    // Field widths of the ports.
    localparam int OUT_YEAR_W = 16;
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;

    // Calendar constants.
    localparam int MONTHS_PER_YEAR = 12;
    localparam int LEAP_CYCLE      = 400;
    localparam int CENTURY         = 100;
    localparam int FEB_DAYS        = 28;
    localparam int SHORT_DAYS      = 30;
    localparam int LONG_DAYS       = 31;
    localparam int MONTH_FEB       = 2;
    localparam int MONTH_APR       = 4;
    localparam int MONTH_JUN       = 6;
    localparam int MONTH_SEP       = 9;
    localparam int MONTH_NOV       = 11;

    // Bias that makes every pre-normalization year positive; a multiple of 400.
    localparam int YEAR_BIAS = 51200;
    localparam int RES_STEPS = 8;

    // Saturation bounds of the output year.
    localparam int YEAR_MAX = 32767;
    localparam int YEAR_MIN = -32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MWRAP,
        ST_RESID,
        ST_DAYS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [OUT_YEAR_W-1:0] year;
        logic [MONTH_W-1:0]           month;
        logic [DOM_W-1:0]             day;
        logic                         overflow;
    } result_t;

endpackage

// ----- rtl/core/cdon_len_unit.sv -----
// Month length unit: Gregorian leap rule from the year residue modulo 400.
// Depends on cdon_pkg.
module cdon_len_unit (
    input  logic                          year_neg,
    input  logic [cdon_pkg::RES_W-1:0]    year_res,
    input  logic [cdon_pkg::MONTH_W-1:0]  month,
    output logic [cdon_pkg::DOM_W-1:0]    len
);

    logic [cdon_pkg::RES_W-1:0] test_res;
    logic                       leap;

    // Map a negative year y to 1-y, modulo 400.
    always_comb
    begin
        if (!year_neg)
        begin
            test_res = year_res;
        end
        else if (year_res <= cdon_pkg::RES_W'(1))
        begin
            test_res = cdon_pkg::RES_W'(1) - year_res;
        end
        else
        begin
            test_res = cdon_pkg::RES_W'(cdon_pkg::LEAP_CYCLE + 1) - year_res;
        end
    end

    // Leap when divisible by 4 and not a plain century.
    assign leap = (test_res[1:0] == 2'b00)
               && (test_res != cdon_pkg::RES_W'(cdon_pkg::CENTURY))
               && (test_res != cdon_pkg::RES_W'(2 * cdon_pkg::CENTURY))
               && (test_res != cdon_pkg::RES_W'(3 * cdon_pkg::CENTURY));

    // Pick the month length.
    always_comb
    begin
        if (month == cdon_pkg::MONTH_W'(cdon_pkg::MONTH_FEB))
        begin
            len = cdon_pkg::DOM_W'(cdon_pkg::FEB_DAYS) + {{(cdon_pkg::DOM_W-1){1'b0}}, leap};
        end
        else if ((month == cdon_pkg::MONTH_W'(cdon_pkg::MONTH_APR))
              || (month == cdon_pkg::MONTH_W'(cdon_pkg::MONTH_JUN))
              || (month == cdon_pkg::MONTH_W'(cdon_pkg::MONTH_SEP))
              || (month == cdon_pkg::MONTH_W'(cdon_pkg::MONTH_NOV)))
        begin
            len = cdon_pkg::DOM_W'(cdon_pkg::SHORT_DAYS);
        end
        else
        begin
            len = cdon_pkg::DOM_W'(cdon_pkg::LONG_DAYS);
        end
    end

endmodule

// ----- rtl/core/cdon_core.sv -----
// Sequencer and datapath: field sums, month wrap, year residue, day stepping.
// Depends on cdon_pkg and cdon_len_unit.
module cdon_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 mode,
    input  logic signed [15:0]   base_year,
    input  logic [3:0]           base_month,
    input  logic [4:0]           base_day,
    input  logic signed [12:0]   offset_years,
    input  logic signed [12:0]   offset_months,
    input  logic signed [15:0]   offset_days,
    input  logic                 res_free,
    output logic                 busy,
    output logic                 done,
    output cdon_pkg::result_t    result
);

    localparam int YW = cdon_pkg::YEAR_W;
    localparam int MW = cdon_pkg::MON_W;
    localparam int DW = cdon_pkg::DAY_W;
    localparam int RW = cdon_pkg::RES_W;
    localparam int AW = cdon_pkg::ACC_W;
    localparam int CW = cdon_pkg::CNT_W;
    localparam int NW = cdon_pkg::MONTH_W;

    cdon_pkg::state_t state_reg, state_next;

    logic signed [YW-1:0] y_reg, y_next;
    logic signed [MW-1:0] m_reg, m_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic [RW-1:0]        res_reg, res_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // Operands of the sums at accept.
    logic signed [YW-1:0] add_y, off_y;
    logic signed [MW-1:0] add_m, off_m;
    logic signed [DW-1:0] add_d, off_d;

    // Day stepping signals.
    logic [NW-1:0]        cur_m, dec_m, inc_m, len_m;
    logic signed [YW-1:0] dec_y;
    logic [RW-1:0]        dec_res, inc_res;
    logic                 borrow;
    logic [cdon_pkg::DOM_W-1:0] len;
    logic signed [DW-1:0] len_ext;

    // Residue reduction trial.
    logic [AW-1:0] sub_val;
    logic [AW:0]   trial;

    assign add_y = YW'(base_year);
    assign off_y = YW'(offset_years);
    assign add_m = MW'({1'b0, base_month}) - MW'(1);
    assign off_m = MW'(offset_months);
    assign add_d = $signed({{(DW-5){1'b0}}, base_day});
    assign off_d = DW'(offset_days);

    assign cur_m   = m_reg[NW-1:0];
    assign borrow  = (d_reg < DW'(1));
    assign dec_m   = (cur_m == NW'(1)) ? NW'(cdon_pkg::MONTHS_PER_YEAR) : cur_m - NW'(1);
    assign inc_m   = (cur_m == NW'(cdon_pkg::MONTHS_PER_YEAR)) ? NW'(1) : cur_m + NW'(1);
    assign dec_y   = (cur_m == NW'(1)) ? y_reg - YW'(1) : y_reg;
    assign dec_res = (res_reg == '0) ? RW'(cdon_pkg::LEAP_CYCLE - 1) : res_reg - RW'(1);
    assign inc_res = (res_reg == RW'(cdon_pkg::LEAP_CYCLE - 1)) ? '0 : res_reg + RW'(1);
    assign len_m   = borrow ? dec_m : cur_m;
    assign len_ext = $signed({{(DW-cdon_pkg::DOM_W){1'b0}}, len});

    assign sub_val = AW'(cdon_pkg::LEAP_CYCLE) << cnt_reg;
    assign trial   = {1'b0, acc_reg} - {1'b0, sub_val};

    // Shared month length unit: the borrow target or the current month.
    cdon_len_unit u_len (
        .year_neg (borrow ? dec_y[YW-1] : y_reg[YW-1]),
        .year_res ((borrow && (cur_m == NW'(1))) ? dec_res : res_reg),
        .month    (len_m),
        .len      (len)
    );

    // Hold state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdon_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        m_reg   <= m_next;
        d_reg   <= d_next;
        res_reg <= res_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    // Sequence the steps.
    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        res_next   = res_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;

        unique case (state_reg)
            cdon_pkg::ST_IDLE:
            begin
                // Add or subtract the offset field by field; month kept zero-based.
                if (start)
                begin
                    if (mode)
                    begin
                        y_next = add_y - off_y;
                        m_next = add_m - off_m;
                        d_next = add_d - off_d;
                    end
                    else
                    begin
                        y_next = add_y + off_y;
                        m_next = add_m + off_m;
                        d_next = add_d + off_d;
                    end
                    state_next = cdon_pkg::ST_MWRAP;
                end
            end

            cdon_pkg::ST_MWRAP:
            begin
                // Wrap the month by twelve a step, carrying into the year.
                if (m_reg < MW'(0))
                begin
                    m_next = m_reg + MW'(cdon_pkg::MONTHS_PER_YEAR);
                    y_next = y_reg - YW'(1);
                end
                else if (m_reg >= MW'(cdon_pkg::MONTHS_PER_YEAR))
                begin
                    m_next = m_reg - MW'(cdon_pkg::MONTHS_PER_YEAR);
                    y_next = y_reg + YW'(1);
                end
                else
                begin
                    m_next     = m_reg + MW'(1);
                    acc_next   = AW'(y_reg + YW'(cdon_pkg::YEAR_BIAS));
                    cnt_next   = CW'(cdon_pkg::RES_STEPS - 1);
                    state_next = cdon_pkg::ST_RESID;
                end
            end

            cdon_pkg::ST_RESID:
            begin
                // Reduce the biased year modulo 400, one shifted subtract a step.
                if (!trial[AW])
                begin
                    acc_next = trial[AW-1:0];
                end
                if (cnt_reg == '0)
                begin
                    res_next   = acc_next[RW-1:0];
                    state_next = cdon_pkg::ST_DAYS;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            cdon_pkg::ST_DAYS:
            begin
                // Borrow from the previous month or carry into the next one.
                if (borrow)
                begin
                    m_next = $signed({{(MW-NW){1'b0}}, dec_m});
                    if (cur_m == NW'(1))
                    begin
                        y_next   = dec_y;
                        res_next = dec_res;
                    end
                    d_next = d_reg + len_ext;
                end
                else if (d_reg > len_ext)
                begin
                    d_next = d_reg - len_ext;
                    m_next = $signed({{(MW-NW){1'b0}}, inc_m});
                    if (cur_m == NW'(cdon_pkg::MONTHS_PER_YEAR))
                    begin
                        y_next   = y_reg + YW'(1);
                        res_next = inc_res;
                    end
                end
                else
                begin
                    state_next = cdon_pkg::ST_FINISH;
                end
            end

            cdon_pkg::ST_FINISH:
            begin
                // Hand the word over once the output register can take it.
                if (res_free)
                begin
                    done       = 1'b1;
                    state_next = cdon_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cdon_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != cdon_pkg::ST_IDLE);

    // Saturate the year into the output range.
    always_comb
    begin
        result.month = cur_m;
        result.day   = d_reg[cdon_pkg::DOM_W-1:0];
        if (y_reg > YW'(cdon_pkg::YEAR_MAX))
        begin
            result.year     = cdon_pkg::OUT_YEAR_W'(cdon_pkg::YEAR_MAX);
            result.overflow = 1'b1;
        end
        else if (y_reg < YW'(cdon_pkg::YEAR_MIN))
        begin
            result.year     = cdon_pkg::OUT_YEAR_W'(cdon_pkg::YEAR_MIN);
            result.overflow = 1'b1;
        end
        else
        begin
            result.year     = y_reg[cdon_pkg::OUT_YEAR_W-1:0];
            result.overflow = 1'b0;
        end
    end

endmodule

// ----- rtl/core/calendar_date_offset_normalize.sv -----
// Top level of the calendar date offset and normalize block.
// Depends on cdon_pkg and cdon_core (which uses cdon_len_unit).
//
// Adds (mode 0) or subtracts (mode 1) a year/month/day offset to a date and
// normalizes the result on the Gregorian calendar. One word is processed at
// a time: in_stall is high from the accept until the result has been moved
// into the output register. After the accept the month sum is wrapped by
// twelve a step, carrying into the year; the biased year is reduced modulo
// 400; the day count is stepped across month boundaries; then the result is
// handed over. The month wrap moves twelve months per cycle, taking about
// |month sum| / 12 steps, and the day stepping moves one month per cycle
// through the shared month length unit, taking about |offset_days| / 30
// steps. The handover waits while the output register still holds a stalled
// word. The output register holds a finished word while the next one is
// accepted. Years beyond -32768..32767 saturate and raise year_overflow.
module calendar_date_offset_normalize (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic signed [15:0]   base_year,
    input  logic [3:0]           base_month,
    input  logic [4:0]           base_day,
    input  logic signed [12:0]   offset_years,
    input  logic signed [12:0]   offset_months,
    input  logic signed [15:0]   offset_days,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   result_year,
    output logic [3:0]           result_month,
    output logic [4:0]           result_day,
    output logic                 year_overflow
);

    logic               busy;
    logic               done;
    logic               res_free;
    cdon_pkg::result_t  core_result;
    cdon_pkg::result_t  out_reg;
    logic               out_valid_reg, out_valid_next;

    assign in_stall = busy;
    assign res_free = !out_valid_reg || !out_stall;

    cdon_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_valid && !busy),
        .mode          (mode),
        .base_year     (base_year),
        .base_month    (base_month),
        .base_day      (base_day),
        .offset_years  (offset_years),
        .offset_months (offset_months),
        .offset_days   (offset_days),
        .res_free      (res_free),
        .busy          (busy),
        .done          (done),
        .result        (core_result)
    );

    // Load a finished word, drop it once taken.
    always_comb
    begin
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_year   = out_reg.year;
    assign result_month  = out_reg.month;
    assign result_day    = out_reg.day;
    assign year_overflow = out_reg.overflow;

endmodule

// ----- tb/calendar_date_offset_normalize_tb.sv -----
// Testbench for calendar_date_offset_normalize: a directed table followed by random
// words, each result checked against a table entry or a predictor of the Gregorian date normalization.
// Depends on cdon_pkg and the calendar_date_offset_normalize RTL.
`timescale 1ns / 100ps

module calendar_date_offset_normalize_tb;
    import cdon_pkg::*;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_SUB   = 1'b1;
    localparam int   LEAP_STEP  = 4;
    localparam int   RAND_ITEMS = 520;
    localparam int   CALM_TAIL  = 60;

    typedef struct {
        logic                 mode;
        logic signed [15:0]   year;
        logic [3:0]           month;
        logic [4:0]           day;
        logic signed [12:0]   dy;
        logic signed [12:0]   dm;
        logic signed [15:0]   dd;
    } date_req_t;

    typedef struct {
        date_req_t req;
        bit        typed;
        result_t   want;
    } table_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic signed [15:0]   base_year;
    logic [3:0]           base_month;
    logic [4:0]           base_day;
    logic signed [12:0]   offset_years;
    logic signed [12:0]   offset_months;
    logic signed [15:0]   offset_days;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [15:0]   result_year;
    logic [3:0]           result_month;
    logic [4:0]           result_day;
    logic                 year_overflow;

    result_t    exp_dates[$];
    table_row_t dir_rows[$];
    int         err_count;
    int         date_count;
    int         stall_left;
    bit         idle_en;

    calendar_date_offset_normalize dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .base_year     (base_year),
        .base_month    (base_month),
        .base_day      (base_day),
        .offset_years  (offset_years),
        .offset_months (offset_months),
        .offset_days   (offset_days),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_year   (result_year),
        .result_month  (result_month),
        .result_day    (result_day),
        .year_overflow (year_overflow)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gregorian leap rule; a negative year y is tested as 1-y
    function automatic bit leap_year(input int y);
        int t;
        t = (y < 0) ? 1 - y : y;
        if (t % LEAP_CYCLE == 0)
            return 1'b1;
        if (t % CENTURY == 0)
            return 1'b0;
        return (t % LEAP_STEP) == 0;
    endfunction

    function automatic int month_days(input int y, input int m);
        if (m == MONTH_FEB)
            return FEB_DAYS + int'(leap_year(y));
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return SHORT_DAYS;
        return LONG_DAYS;
    endfunction

    // Apply the offset, wrap the month, then walk days across month boundaries
    function automatic result_t predict_date(input date_req_t r);
        int      y;
        int      m;
        int      d;
        int      m0;
        int      q;
        result_t res;
        if (r.mode == MODE_SUB)
        begin
            y = int'(r.year) - int'(r.dy);
            m = int'(r.month) - int'(r.dm);
            d = int'(r.day) - int'(r.dd);
        end
        else
        begin
            y = int'(r.year) + int'(r.dy);
            m = int'(r.month) + int'(r.dm);
            d = int'(r.day) + int'(r.dd);
        end
        // floor division of the zero-based month by twelve
        m0 = m - 1;
        q  = (m0 >= 0) ? m0 / MONTHS_PER_YEAR
                       : -((-m0 + MONTHS_PER_YEAR - 1) / MONTHS_PER_YEAR);
        m  = m0 - MONTHS_PER_YEAR * q + 1;
        y  = y + q;
        // borrow from earlier months
        while (d < 1)
        begin
            m = m - 1;
            if (m < 1)
            begin
                m = m + MONTHS_PER_YEAR;
                y = y - 1;
            end
            d = d + month_days(y, m);
        end
        // carry into later months
        while (d > month_days(y, m))
        begin
            d = d - month_days(y, m);
            m = m + 1;
            if (m > MONTHS_PER_YEAR)
            begin
                m = m - MONTHS_PER_YEAR;
                y = y + 1;
            end
        end
        res.overflow = (y > YEAR_MAX) || (y < YEAR_MIN);
        if (y > YEAR_MAX)
            res.year = 16'(YEAR_MAX);
        else if (y < YEAR_MIN)
            res.year = 16'(YEAR_MIN);
        else
            res.year = 16'(y);
        res.month = 4'(m);
        res.day   = 5'(d);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns, date %0d: %s", $time, date_count, what);
        err_count = err_count + 1;
    endtask

    task automatic table_row(input logic md, input int y, input int mo, input int d,
                             input int oy, input int om, input int od, input bit typed,
                             input int ey, input int em, input int ed, input bit eo);
        table_row_t row;
        row.req.mode     = md;
        row.req.year     = 16'(y);
        row.req.month    = 4'(mo);
        row.req.day      = 5'(d);
        row.req.dy       = 13'(oy);
        row.req.dm       = 13'(om);
        row.req.dd       = 16'(od);
        row.typed        = typed;
        row.want.year    = 16'(ey);
        row.want.month   = 4'(em);
        row.want.day     = 5'(ed);
        row.want.overflow = eo;
        dir_rows.push_back(row);
    endtask

    // Mostly plausible dates with small offsets, some full-range words
    function automatic date_req_t random_request();
        date_req_t r;
        int        kind;
        int        step;
        int        yr;
        kind   = $urandom_range(0, 9);
        r.mode = 1'($urandom);
        if (kind < 2)
        begin
            r.year  = 16'($urandom);
            r.month = 4'($urandom);
            r.day   = 5'($urandom);
            r.dy    = 13'($urandom);
            r.dm    = 13'($urandom);
            r.dd    = 16'($urandom);
        end
        else if (kind < 8)
        begin
            r.year  = 16'($urandom);
            r.month = 4'($urandom_range(1, 12));
            r.day   = 5'($urandom_range(1, 31));
            r.dy    = ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                  : 13'(int'($urandom_range(0, 100)) - 50);
            r.dm    = 13'(int'($urandom_range(0, 60)) - 30);
            r.dd    = 16'(int'($urandom_range(0, 800)) - 400);
        end
        else if (kind == 8)
        begin
            // around the end of February on century, quad and plain years
            case ($urandom_range(0, 2))
                0:       step = LEAP_CYCLE;
                1:       step = CENTURY;
                default: step = LEAP_STEP;
            endcase
            yr      = int'($urandom_range(0, 64000 / step)) * step - 32000
                      + int'($urandom_range(0, 1));
            r.year  = 16'(yr);
            r.month = 4'($urandom_range(2, 3));
            r.day   = 5'($urandom_range(1, 29));
            r.dy    = 13'(int'($urandom_range(0, 2)) - 1);
            r.dm    = 13'(int'($urandom_range(0, 2)) - 1);
            r.dd    = 16'(int'($urandom_range(0, 60)) - 30);
        end
        else
        begin
            // near the ends of the year range
            r.year  = ($urandom_range(0, 1) == 1) ? 16'(YEAR_MAX - int'($urandom_range(0, 8)))
                                                  : 16'(YEAR_MIN + int'($urandom_range(0, 8)));
            r.month = 4'($urandom_range(1, 12));
            r.day   = 5'($urandom_range(1, 31));
            r.dy    = 13'(int'($urandom_range(0, 16)) - 8);
            r.dm    = 13'(int'($urandom_range(0, 24)) - 12);
            r.dd    = 16'(int'($urandom_range(0, 800)) - 400);
        end
        return r;
    endfunction

    // Present one word, hold it until accepted, then queue its expected date
    task automatic send_word(input date_req_t r, input bit typed, input result_t want,
                             input bit gaps_on);
        int gap;
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= r.mode;
        base_year     <= r.year;
        base_month    <= r.month;
        base_day      <= r.day;
        offset_years  <= r.dy;
        offset_months <= r.dm;
        offset_days   <= r.dd;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        exp_dates.push_back(typed ? want : predict_date(r));
    endtask

    // Drive reset, the directed table, then random words
    initial
    begin : stimulus
        date_req_t r;
        result_t   none;
        bit        gaps_on;
        none          = '0;
        err_count     = 0;
        date_count    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= MODE_ADD;
        base_year     <= '0;
        base_month    <= '0;
        base_day      <= '0;
        offset_years  <= '0;
        offset_months <= '0;
        offset_days   <= '0;
        idle_en       <= 1'b1;

        // leap rule on plain, century, quad-century and BC years
        table_row(MODE_ADD,   2024,  2, 29,     0,     0,      0, 1,   2024,  2, 29, 0);
        table_row(MODE_ADD,   2023,  2, 29,     0,     0,      0, 1,   2023,  3,  1, 0);
        table_row(MODE_ADD,   2000,  2, 29,     0,     0,      0, 1,   2000,  2, 29, 0);
        table_row(MODE_ADD,   1900,  2, 29,     0,     0,      0, 1,   1900,  3,  1, 0);
        table_row(MODE_ADD,     -3,  2, 29,     0,     0,      0, 1,     -3,  2, 29, 0);
        table_row(MODE_ADD,     -1,  2, 29,     0,     0,      0, 1,     -1,  3,  1, 0);
        // saturation at both ends of the year range
        table_row(MODE_ADD,  32767, 12, 31,     0,     0,      1, 1,  32767,  1,  1, 1);
        table_row(MODE_ADD, -32768,  1,  1,     0,     0,     -1, 1, -32768, 12, 31, 1);
        // month and year wrap by one step
        table_row(MODE_ADD,   2021, 12, 31,     0,     1,      0, 1,   2022,  1, 31, 0);
        table_row(MODE_SUB,   2021,  1,  1,     0,     0,      1, 1,   2020, 12, 31, 0);
        // field extremes, checked by the predictor
        table_row(MODE_ADD,  32767,  6, 15,  4095,     0,      0, 0, 0, 0, 0, 0);
        table_row(MODE_SUB, -32768,  6, 15,  4095,     0,      0, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,   2000,  1,  1,     0,     0,  32767, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,   2000,  1,  1,     0,     0, -32768, 0, 0, 0, 0, 0);
        table_row(MODE_SUB,   1999, 12, 31,     0,     0, -32768, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,      1,  1,  1,     0,  4095,      0, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,      1,  1,  1,     0, -4096,      0, 0, 0, 0, 0, 0);
        table_row(MODE_SUB,      1, 12, 31,     0, -4096,      0, 0, 0, 0, 0, 0);
        // start month and day outside their calendar range, or a day past the end of the target month
        table_row(MODE_ADD,      0,  0,  0,     0,     0,      0, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,   2020, 15, 31,     0,     0,      0, 0, 0, 0, 0, 0);
        table_row(MODE_SUB,   2021,  3, 31,     0,     1,      0, 0, 0, 0, 0, 0);
        // every offset at its extreme at once
        table_row(MODE_SUB,    100,  2, 28, -4096,  4095,  32767, 0, 0, 0, 0, 0);
        table_row(MODE_ADD, -32768,  1,  1, -4096, -4096, -32768, 0, 0, 0, 0, 0);
        table_row(MODE_ADD,  32767, 12, 31,  4095,  4095,  32767, 0, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, 1'b1);

        // random words; calm stretches, and none at all near the end
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            gaps_on = (i < RAND_ITEMS - CALM_TAIL) && ((i / 40) % 3 != 2);
            idle_en <= gaps_on;
            r = random_request();
            send_word(r, 1'b0, none, gaps_on);
        end
        in_valid <= 1'b0;

        // drain outstanding dates, then watch a little longer for strays
        while (exp_dates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hold off the result side in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall  <= 1'b0;
        end
        else
        begin
            if (stall_left != 0)
                stall_left = stall_left - 1;
            else if (idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            out_stall <= (stall_left != 0);
        end
    end

    // Compare each accepted result word with the oldest expected date
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_dates.size() == 0)
                report_mismatch("result word with no date expected");
            else
            begin
                want = exp_dates.pop_front();
                if (result_year !== want.year)
                    report_mismatch($sformatf("year got %0d expected %0d",
                                              result_year, want.year));
                if (result_month !== want.month)
                    report_mismatch($sformatf("month got %0d expected %0d",
                                              result_month, want.month));
                if (result_day !== want.day)
                    report_mismatch($sformatf("day got %0d expected %0d",
                                              result_day, want.day));
                if (year_overflow !== want.overflow)
                    report_mismatch($sformatf("year_overflow got %0b expected %0b",
                                              year_overflow, want.overflow));
            end
            date_count = date_count + 1;
        end
    end

    // Stop a hung run
    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cdon_pkg.sv
rtl/core/cdon_len_unit.sv
rtl/core/cdon_core.sv
rtl/core/calendar_date_offset_normalize.sv
tb/calendar_date_offset_normalize_tb.sv
